[sv/qvr_pkg.sv]
// Shared widths, types and register codes of the quaternion vector rotation unit.
package qvr_pkg;

  localparam int COORD_WIDTH    = 16;
  localparam int QUAT_FRAC_BITS = 14;
  localparam int QUAT_WIDTH     = 16;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // q*v products, p = q*(0,v) sums, negated quaternion, p*conj(q) products and sums
  localparam int PROD1_W     = COORD_WIDTH + QUAT_WIDTH;
  localparam int P_W         = PROD1_W + 1;
  localparam int QN_W        = QUAT_WIDTH + 1;
  localparam int PROD2_W     = P_W + QN_W;
  localparam int SUM_W       = PROD2_W + 2;
  localparam int ROUND_SHIFT = 2 * QUAT_FRAC_BITS;

  localparam int VEC_BITS = 3 * COORD_WIDTH;
  localparam int TDATA_W  = ((VEC_BITS + 7) / 8) * 8;

  localparam logic [QUAT_WIDTH-1:0] QUAT_W_RESET = QUAT_WIDTH'(1 << QUAT_FRAC_BITS);
  localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'(1) << (ROUND_SHIFT - 1);

  typedef enum logic [1:0] {
    REG_QUAT_W = 2'd0,
    REG_QUAT_X = 2'd1,
    REG_QUAT_Y = 2'd2,
    REG_QUAT_Z = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [QUAT_WIDTH-1:0] z;
    logic [QUAT_WIDTH-1:0] y;
    logic [QUAT_WIDTH-1:0] x;
    logic [QUAT_WIDTH-1:0] w;
  } quat_t;

  // x in the lowest bits
  typedef struct packed {
    logic [COORD_WIDTH-1:0] z;
    logic [COORD_WIDTH-1:0] y;
    logic [COORD_WIDTH-1:0] x;
  } vec_t;

  typedef struct packed {
    logic [P_W-1:0] z;
    logic [P_W-1:0] y;
    logic [P_W-1:0] x;
    logic [P_W-1:0] w;
  } pquat_t;

  typedef struct packed {
    logic [SUM_W-1:0] z;
    logic [SUM_W-1:0] y;
    logic [SUM_W-1:0] x;
  } rsum_t;

  // valid/ready pair between pipeline sections
  typedef struct packed {
    logic valid;
  } fwd_t;

  typedef struct packed {
    logic ready;
  } bwd_t;

endpackage

[sv/qvr_cfg_regs.sv]
// APB register file holding the rotation quaternion.
module qvr_cfg_regs import qvr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output quat_t                 quat
);

  quat_t    quat_r;
  quat_t    quat_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite & pready;
  assign quat   = quat_r;

  always_comb begin
    quat_nxt = quat_r;
    if (wr_en) begin
      case (idx)
        REG_QUAT_W: quat_nxt.w = pwdata[QUAT_WIDTH-1:0];
        REG_QUAT_X: quat_nxt.x = pwdata[QUAT_WIDTH-1:0];
        REG_QUAT_Y: quat_nxt.y = pwdata[QUAT_WIDTH-1:0];
        REG_QUAT_Z: quat_nxt.z = pwdata[QUAT_WIDTH-1:0];
        default:    quat_nxt   = quat_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quat_r.w <= QUAT_W_RESET;
      quat_r.x <= '0;
      quat_r.y <= '0;
      quat_r.z <= '0;
    end else begin
      quat_r <= quat_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_QUAT_W: prdata = CFG_DATA_W'(quat_r.w);
      REG_QUAT_X: prdata = CFG_DATA_W'(quat_r.x);
      REG_QUAT_Y: prdata = CFG_DATA_W'(quat_r.y);
      REG_QUAT_Z: prdata = CFG_DATA_W'(quat_r.z);
      default:    prdata = '0;
    endcase
  end

endmodule

[sv/qvr_vec_mul.sv]
// Two pipeline stages forming p = q * (0, v): twelve products, then the four sums.
module qvr_vec_mul import qvr_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  quat_t  quat,
  input  fwd_t   up_fwd,
  output bwd_t   up_bwd,
  input  vec_t   in_vec,
  output fwd_t   dn_fwd,
  input  bwd_t   dn_bwd,
  output pquat_t out_p
);

  logic signed [QUAT_WIDTH-1:0]  q_s [4];
  logic signed [COORD_WIDTH-1:0] v_s [3];
  logic signed [PROD1_W-1:0]     qv_nxt [4][3];
  logic signed [PROD1_W-1:0]     qv_r [4][3];
  logic signed [P_W-1:0]         pw, px, py, pz;
  pquat_t                        p_nxt;
  pquat_t                        p_r;
  logic                          s1_valid_r, s2_valid_r;
  logic                          adv1, adv2;

  assign q_s[0] = $signed(quat.w);
  assign q_s[1] = $signed(quat.x);
  assign q_s[2] = $signed(quat.y);
  assign q_s[3] = $signed(quat.z);
  assign v_s[0] = $signed(in_vec.x);
  assign v_s[1] = $signed(in_vec.y);
  assign v_s[2] = $signed(in_vec.z);

  // a stage advances when empty or when the next one advances
  assign adv2         = !s2_valid_r || dn_bwd.ready;
  assign adv1         = !s1_valid_r || adv2;
  assign up_bwd.ready = adv1;
  assign dn_fwd.valid = s2_valid_r;
  assign out_p        = p_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 3; j++) begin
        qv_nxt[i][j] = q_s[i] * v_s[j];
      end
    end
  end

  // rows w,x,y,z of q; columns x,y,z of v
  always_comb begin
    pw = -P_W'(qv_r[1][0]) - P_W'(qv_r[2][1]) - P_W'(qv_r[3][2]);
    px =  P_W'(qv_r[0][0]) + P_W'(qv_r[2][2]) - P_W'(qv_r[3][1]);
    py =  P_W'(qv_r[0][1]) + P_W'(qv_r[3][0]) - P_W'(qv_r[1][2]);
    pz =  P_W'(qv_r[0][2]) + P_W'(qv_r[1][1]) - P_W'(qv_r[2][0]);
    p_nxt.w = pw;
    p_nxt.x = px;
    p_nxt.y = py;
    p_nxt.z = pz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (adv1) s1_valid_r <= up_fwd.valid;
      if (adv2) s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && up_fwd.valid) qv_r <= qv_nxt;
    if (adv2 && s1_valid_r)   p_r  <= p_nxt;
  end

endmodule

[sv/qvr_conj_mul.sv]
// Two pipeline stages forming the vector part of p * conj(q), with the rounding bias added.
module qvr_conj_mul import qvr_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  quat_t  quat,
  input  fwd_t   up_fwd,
  output bwd_t   up_bwd,
  input  pquat_t in_p,
  output fwd_t   dn_fwd,
  input  bwd_t   dn_bwd,
  output rsum_t  out_sum
);

  logic signed [P_W-1:0]     pw, px, py, pz;
  logic signed [QN_W-1:0]    ew, ex, ey, ez;
  logic signed [QN_W-1:0]    nx, ny, nz;
  logic signed [PROD2_W-1:0] m_nxt [3][4];
  logic signed [PROD2_W-1:0] m_r [3][4];
  logic signed [SUM_W-1:0]   acc [3];
  rsum_t                     sum_r;
  logic                      s1_valid_r, s2_valid_r;
  logic                      adv1, adv2;

  assign pw = $signed(in_p.w);
  assign px = $signed(in_p.x);
  assign py = $signed(in_p.y);
  assign pz = $signed(in_p.z);
  assign ew = QN_W'($signed(quat.w));
  assign ex = QN_W'($signed(quat.x));
  assign ey = QN_W'($signed(quat.y));
  assign ez = QN_W'($signed(quat.z));
  assign nx = -ex;
  assign ny = -ey;
  assign nz = -ez;

  assign adv2         = !s2_valid_r || dn_bwd.ready;
  assign adv1         = !s1_valid_r || adv2;
  assign up_bwd.ready = adv1;
  assign dn_fwd.valid = s2_valid_r;
  assign out_sum      = sum_r;

  always_comb begin
    m_nxt[0][0] = pw * nx;
    m_nxt[0][1] = px * ew;
    m_nxt[0][2] = py * nz;
    m_nxt[0][3] = pz * ey;
    m_nxt[1][0] = pw * ny;
    m_nxt[1][1] = py * ew;
    m_nxt[1][2] = pz * nx;
    m_nxt[1][3] = px * ez;
    m_nxt[2][0] = pw * nz;
    m_nxt[2][1] = pz * ew;
    m_nxt[2][2] = px * ny;
    m_nxt[2][3] = py * ex;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = SUM_W'(m_r[i][0]) + SUM_W'(m_r[i][1]) + SUM_W'(m_r[i][2])
             + SUM_W'(m_r[i][3]) + ROUND_BIAS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (adv1) s1_valid_r <= up_fwd.valid;
      if (adv2) s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && up_fwd.valid) m_r <= m_nxt;
    if (adv2 && s1_valid_r) begin
      sum_r.x <= acc[0];
      sum_r.y <= acc[1];
      sum_r.z <= acc[2];
    end
  end

endmodule

[sv/qvr_round_sat.sv]
// Output stage: drop the fraction bits, saturate each coordinate, hold the result for transfer.
module qvr_round_sat import qvr_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  fwd_t  up_fwd,
  output bwd_t  up_bwd,
  input  rsum_t in_sum,
  output fwd_t  dn_fwd,
  input  bwd_t  dn_bwd,
  output vec_t  out_rot,
  output logic  out_clip
);

  localparam logic signed [SUM_W-1:0] C_MAX = SUM_W'((1 << (COORD_WIDTH - 1)) - 1);
  localparam logic signed [SUM_W-1:0] C_MIN = ~C_MAX;

  logic signed [SUM_W-1:0]       sh [3];
  logic signed [COORD_WIDTH-1:0] sat [3];
  logic [2:0]                    hit;
  vec_t                          rot_r;
  logic                          clip_r;
  logic                          valid_r;
  logic                          adv;

  assign adv          = !valid_r || dn_bwd.ready;
  assign up_bwd.ready = adv;
  assign dn_fwd.valid = valid_r;
  assign out_rot      = rot_r;
  assign out_clip     = clip_r;

  assign sh[0] = $signed(in_sum.x) >>> ROUND_SHIFT;
  assign sh[1] = $signed(in_sum.y) >>> ROUND_SHIFT;
  assign sh[2] = $signed(in_sum.z) >>> ROUND_SHIFT;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (sh[i] > C_MAX) begin
        sat[i] = C_MAX[COORD_WIDTH-1:0];
        hit[i] = 1'b1;
      end else if (sh[i] < C_MIN) begin
        sat[i] = C_MIN[COORD_WIDTH-1:0];
        hit[i] = 1'b1;
      end else begin
        sat[i] = sh[i][COORD_WIDTH-1:0];
        hit[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= up_fwd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && up_fwd.valid) begin
      rot_r.x <= sat[0];
      rot_r.y <= sat[1];
      rot_r.z <= sat[2];
      clip_r  <= |hit;
    end
  end

endmodule

[sv/vector_rotate_by_quaternion_unit.sv]
// Top level of the quaternion vector rotation unit.
//
//  channel | direction | handshake          | payload
//  in_     | slave     | in_tvalid/tready   | in_tdata: vec_x, vec_y, vec_z
//  out_    | master    | out_tvalid/tready  | out_tdata: rot_x, rot_y, rot_z; out_tuser: clipped
//  cfg_    | APB slave | psel/penable/pready| quat_w, quat_x, quat_y, quat_z at 0x0..0xC
//
// One vector per cycle while the output is not stalled; vectors pass the product and sum stages
// of q*(0,v), the product and sum stages of p*conj(q) and the round/saturate output register.
// Synchronous active-low reset empties the pipeline and loads the identity quaternion.
// A stall on out_tready fills empty stages first; in_tready drops only once every
// stage holds an item and the output transfer is stalled.
module vector_rotate_by_quaternion_unit import qvr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [TDATA_W-1:0]    in_tdata,    // vec_x, vec_y, vec_z
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [TDATA_W-1:0]    out_tdata,   // rot_x, rot_y, rot_z
  output logic [0:0]            out_tuser,   // clipped
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  quat_t  quat;
  vec_t   in_vec;
  vec_t   rot;
  pquat_t p;
  rsum_t  rsum;
  logic   clip;
  fwd_t   in_fwd, a_fwd, b_fwd, out_fwd;
  bwd_t   in_bwd, a_bwd, b_bwd, out_bwd;

  assign in_vec        = in_tdata[VEC_BITS-1:0];
  assign in_fwd.valid  = in_tvalid;
  assign in_tready     = in_bwd.ready;
  assign out_bwd.ready = out_tready;
  assign out_tvalid    = out_fwd.valid;
  assign out_tdata     = TDATA_W'(rot);
  assign out_tuser     = clip;

  qvr_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .quat    (quat)
  );

  qvr_vec_mul u_vec_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .quat   (quat),
    .up_fwd (in_fwd),
    .up_bwd (in_bwd),
    .in_vec (in_vec),
    .dn_fwd (a_fwd),
    .dn_bwd (a_bwd),
    .out_p  (p)
  );

  qvr_conj_mul u_conj_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .quat    (quat),
    .up_fwd  (a_fwd),
    .up_bwd  (a_bwd),
    .in_p    (p),
    .dn_fwd  (b_fwd),
    .dn_bwd  (b_bwd),
    .out_sum (rsum)
  );

  qvr_round_sat u_round_sat (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_fwd   (b_fwd),
    .up_bwd   (b_bwd),
    .in_sum   (rsum),
    .dn_fwd   (out_fwd),
    .dn_bwd   (out_bwd),
    .out_rot  (rot),
    .out_clip (clip)
  );

endmodule

[sv/qvr_checker.sv]
// Port-level checker for the quaternion vector rotation unit, bound to the top level.
module qvr_checker import qvr_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [TDATA_W-1:0]    out_tdata,
  input logic [0:0]            out_tuser,
  input logic                  cfg_pready
);

  localparam logic [COORD_WIDTH-1:0] C_MAX = COORD_WIDTH'((1 << (COORD_WIDTH - 1)) - 1);
  localparam logic [COORD_WIDTH-1:0] C_MIN = ~C_MAX;

  logic [COORD_WIDTH-1:0] rx, ry, rz;

  assign rx = out_tdata[COORD_WIDTH-1:0];
  assign ry = out_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
  assign rz = out_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];

  // pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high right after reset");

  // back-pressure reaches the input only through a stalled, full output
  a_ready_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("in_tready low while output not stalled");

  // clipped result must sit on a range limit
  a_clip_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |->
      (rx == C_MAX || rx == C_MIN || ry == C_MAX || ry == C_MIN ||
       rz == C_MAX || rz == C_MIN))
    else $error("clipped set with no coordinate at a limit");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled output transfer changed");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("cfg_pready low");

endmodule

bind vector_rotate_by_quaternion_unit qvr_checker u_qvr_checker (.*);
